@@ rtl/core/tts_pkg.sv @@
// shared types, constants and arithmetic helpers of the tridiagonal solver
package tts_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int WORD_W = 32;
   localparam int ROW_W = 6;

   typedef struct packed {
      logic signed [WORD_W-1:0] lower_coef;
      logic signed [WORD_W-1:0] diag_coef;
      logic signed [WORD_W-1:0] upper_coef;
      logic signed [WORD_W-1:0] rhs_value;
      logic last_row;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] solution_value;
      logic [ROW_W-1:0] row_index;
      logic pivot_floored;
      logic last_result;
   } rsp_type;

   function automatic logic signed [WORD_W-1:0] sat_50(input logic signed [49:0] v);
      logic signed [WORD_W-1:0] r;
      begin
         if (v > 50'sd2147483647) r = 32'sh7fffffff;
         else if (v < -50'sd2147483648) r = 32'sh80000000;
         else r = v[WORD_W-1:0];
         return r;
      end
   endfunction

endpackage

@@ rtl/core/tts_divider.sv @@
// serial signed q16.16 divider, quotient truncated toward zero and saturated
module tts_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [tts_pkg::WORD_W-1:0] num,
   input  logic signed [tts_pkg::WORD_W-1:0] den,
   output logic done,
   output logic signed [tts_pkg::WORD_W-1:0] quot
);
   localparam int QW = 48;
   logic [QW-1:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] an, ad;
   logic [33:0] t0, t1;
   logic [32:0] r1;
   logic [QW-1:0] q1;
   logic signed [49:0] sq;

   always_comb begin
      an = num[31] ? 32'(-num) : num;
      ad = (den == '0) ? 32'd1 : (den[31] ? 32'(-den) : den);
      q_in = q_ff; rem_in = rem_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      r1 = rem_ff; q1 = q_ff;
      t0 = '0; t1 = '0;
      if (start) begin
         q_in = {an, 16'd0};
         rem_in = '0;
         d_in = ad;
         neg_in = num[31] ^ (den[31] && den != '0);
         cnt_in = 6'(QW / 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         t0 = {r1, q1[QW-1]} - {2'b0, d_ff};
         if (!t0[33]) r1 = t0[32:0]; else r1 = {r1[31:0], q1[QW-1]};
         q1 = {q1[QW-2:0], !t0[33]};
         t1 = {r1, q1[QW-1]} - {2'b0, d_ff};
         if (!t1[33]) r1 = t1[32:0]; else r1 = {r1[31:0], q1[QW-1]};
         q1 = {q1[QW-2:0], !t1[33]};
         rem_in = r1; q_in = q1;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      sq = neg_ff ? -$signed({2'b0, q_ff}) : $signed({2'b0, q_ff});
      if (sq > 50'sd2147483647) quot = 32'sh7fffffff;
      else if (sq < -50'sd2147483648) quot = 32'sh80000000;
      else quot = sq[31:0];
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; rem_ff <= rem_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
endmodule

@@ rtl/core/tts_front.sv @@
// input queue between the row port and the elimination engine
module tts_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  tts_pkg::req_type req_data,
   output logic req_full,
   input  logic take,
   output logic avail,
   output tts_pkg::req_type head
);
   tts_pkg::req_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push_ok, pop_ok;

   assign push_ok = req_push && !req_full;
   assign pop_ok = take && avail;
   assign req_full = (cnt_ff == 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign head = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
      rd_in = rd_ff ^ pop_ok;
      wr_in = wr_ff ^ push_ok;
   end

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= req_data;
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; rd_ff <= rd_in; wr_ff <= wr_in;
      end
   end
endmodule

@@ rtl/core/tts_back.sv @@
// elimination and back substitution sequencer with row stores
module tts_back #(
   parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic avail,
   input  tts_pkg::req_type head,
   output logic take,
   output logic rsp_empty,
   input  logic rsp_pop,
   output tts_pkg::rsp_type rsp_data
);
   localparam int IW = $clog2(MAX_ROWS);
   localparam int W = tts_pkg::WORD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RDIV, S_RMUL, S_RSUB, S_NRD, S_NMUL, S_PDIV, S_PWAIT,
      S_BRD, S_BMUL, S_BSUB, S_ORD, S_OUT
   } state_type;

   state_type st_ff;
   logic signed [W-1:0] ratio_mem [MAX_ROWS];
   logic signed [W-1:0] part_mem [MAX_ROWS];
   logic flag_mem [MAX_ROWS];

   tts_pkg::req_type row_ff;
   logic signed [W-1:0] piv_ff, pu_ff, g_ff, pv_ff, num_ff, rdp_ff, rdg_ff;
   logic signed [63:0] prod_ff;
   logic [IW-1:0] idx_ff, n_ff, j_ff;
   logic flr_ff;
   logic rflag_ff;

   logic dstart, ddone;
   logic signed [W-1:0] dnum, dden, dq;
   logic signed [W-1:0] mul_a, mul_b;
   logic signed [47:0] pfloor;

   tts_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .done(ddone), .quot(dq)
   );

   assign pfloor = prod_ff[63:16];
   assign take = (st_ff == S_IDLE) && avail;
   assign rsp_empty = (st_ff != S_OUT);
   assign rsp_data.solution_value = rdp_ff;
   assign rsp_data.row_index = tts_pkg::ROW_W'(j_ff);
   assign rsp_data.pivot_floored = rflag_ff;
   assign rsp_data.last_result = (j_ff == n_ff);

   always_comb begin
      dstart = 1'b0;
      dnum = pu_ff;
      dden = piv_ff;
      if (st_ff == S_IDLE && avail && idx_ff != '0) dstart = 1'b1;
      if (st_ff == S_PDIV) begin
         dstart = 1'b1;
         dnum = num_ff;
         dden = flr_ff ? 32'sd1 : pv_ff;
      end
      mul_a = row_ff.lower_coef;
      mul_b = g_ff;
      if (st_ff == S_NMUL) begin
         mul_b = rdp_ff;
      end
      if (st_ff == S_BMUL) begin
         mul_a = rdg_ff;
         mul_b = rdp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         idx_ff <= '0;
         piv_ff <= '0;
         pu_ff <= '0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (avail) begin
               row_ff <= head;
               if (idx_ff == '0) begin
                  pv_ff <= head.diag_coef;
                  num_ff <= head.rhs_value;
                  flr_ff <= (head.diag_coef == '0);
                  st_ff <= S_PDIV;
               end else st_ff <= S_RDIV;
            end
            S_RDIV: if (ddone) begin
               g_ff <= dq;
               ratio_mem[idx_ff] <= dq;
               st_ff <= S_RMUL;
            end
            S_RMUL: begin
               prod_ff <= mul_a * mul_b;
               rdp_ff <= part_mem[idx_ff - 1'b1];
               st_ff <= S_RSUB;
            end
            S_RSUB: begin
               pv_ff <= tts_pkg::sat_50(50'(row_ff.diag_coef) - 50'(pfloor));
               flr_ff <= (tts_pkg::sat_50(50'(row_ff.diag_coef) - 50'(pfloor)) == '0);
               st_ff <= S_NMUL;
            end
            S_NMUL: begin
               prod_ff <= mul_a * mul_b;
               st_ff <= S_NRD;
            end
            S_NRD: begin
               num_ff <= tts_pkg::sat_50(50'(row_ff.rhs_value) - 50'(pfloor));
               st_ff <= S_PDIV;
            end
            S_PDIV: begin
               piv_ff <= flr_ff ? 32'sd1 : pv_ff;
               pu_ff <= row_ff.upper_coef;
               flag_mem[idx_ff] <= flr_ff;
               st_ff <= S_PWAIT;
            end
            S_PWAIT: if (ddone) begin
               part_mem[idx_ff] <= dq;
               rdp_ff <= dq;
               if (row_ff.last_row || idx_ff == IW'(MAX_ROWS - 1)) begin
                  n_ff <= idx_ff;
                  j_ff <= idx_ff;
                  idx_ff <= '0;
                  piv_ff <= '0;
                  pu_ff <= '0;
                  st_ff <= (idx_ff == '0) ? S_ORD : S_BRD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_IDLE;
               end
            end
            S_BRD: begin
               rdg_ff <= ratio_mem[j_ff];
               pv_ff <= part_mem[j_ff - 1'b1];
               j_ff <= j_ff - 1'b1;
               st_ff <= S_BMUL;
            end
            S_BMUL: begin
               prod_ff <= mul_a * mul_b;
               st_ff <= S_BSUB;
            end
            S_BSUB: begin
               rdp_ff <= tts_pkg::sat_50(50'(pv_ff) - 50'(pfloor));
               part_mem[j_ff] <= tts_pkg::sat_50(50'(pv_ff) - 50'(pfloor));
               st_ff <= (j_ff == '0) ? S_ORD : S_BRD;
            end
            S_ORD: begin
               rdp_ff <= part_mem[j_ff];
               rflag_ff <= flag_mem[j_ff];
               st_ff <= S_OUT;
            end
            S_OUT: if (rsp_pop) begin
               if (j_ff == n_ff) st_ff <= S_IDLE;
               else begin
                  j_ff <= j_ff + 1'b1;
                  st_ff <= S_ORD;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/core/tridiagonal_thomas_solver.sv @@
// tridiagonal system solver, top level
// forward elimination per row: two serial divides plus multiply and subtract steps
// (one divide for the first row of a system), bound by the shared radix-4 divider
// after the last row: back substitution row by row, then the results in row order
// reset (synchronous, active high) empties the queue and starts a new system
module tridiagonal_thomas_solver #(
   parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  tts_pkg::req_type req_data,
   output logic empty,
   input  logic pop,
   output tts_pkg::rsp_type rsp_data
);
   logic take, avail;
   tts_pkg::req_type head;

   tts_front u_front (
      .clock(clock), .reset(reset), .req_push(push), .req_data(req_data),
      .req_full(full), .take(take), .avail(avail), .head(head)
   );

   tts_back #(.MAX_ROWS(MAX_ROWS)) u_back (
      .clock(clock), .reset(reset), .avail(avail), .head(head), .take(take),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data)
   );
endmodule

@@ bench/tridiagonal_thomas_solver_tb.sv @@
// testbench of the tridiagonal solver: random systems checked against a fixed-point predictor
module tridiagonal_thomas_solver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 64;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   tts_pkg::req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   tts_pkg::rsp_type rsp_data;

   tts_pkg::req_type row_queue[$];
   int gap_queue[$];
   tts_pkg::rsp_type solution_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   int pop_wait = 0;
   int push_wait = 0;
   bit drain_hold = 1'b0;

   // predictor state
   logic signed [31:0] ratio_mem[ROWS];
   logic signed [31:0] partial_mem[ROWS];
   logic floor_mem[ROWS];
   logic signed [31:0] pivot_reg = '0;
   logic signed [31:0] upper_reg = '0;
   int row_cnt = 0;

   always #2 clock = ~clock;

   tridiagonal_thomas_solver i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> 16;
   endfunction

   function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
                                               input logic signed [31:0] d);
      logic signed [63:0] num;
      logic signed [63:0] den;
      num = 64'(n) <<< 16;
      den = (d == 0) ? 64'sd1 : 64'(d);
      return sat(num / den);
   endfunction

   task automatic predict_row(input tts_pkg::req_type r);
      int idx;
      logic signed [31:0] piv;
      logic signed [31:0] num;
      logic signed [31:0] g;
      logic fl;
      tts_pkg::rsp_type s;
      idx = (row_cnt >= ROWS) ? 0 : row_cnt;
      if (idx == 0) begin
         piv = r.diag_coef;
         num = r.rhs_value;
      end else begin
         g = qdiv(upper_reg, pivot_reg);
         ratio_mem[idx] = g;
         piv = sat(64'(r.diag_coef) - qmul(r.lower_coef, g));
         num = sat(64'(r.rhs_value) - qmul(r.lower_coef, partial_mem[idx-1]));
      end
      fl = (piv == 0);
      if (fl) piv = 32'sd1;
      partial_mem[idx] = qdiv(num, piv);
      floor_mem[idx] = fl;
      pivot_reg = piv;
      upper_reg = r.upper_coef;
      if (!r.last_row && idx + 1 < ROWS) begin
         row_cnt = idx + 1;
         return;
      end
      for (int j = idx - 1; j >= 0; j--)
         partial_mem[j] = sat(64'(partial_mem[j]) - qmul(ratio_mem[j+1], partial_mem[j+1]));
      for (int k = 0; k <= idx; k++) begin
         s.solution_value = partial_mem[k];
         s.row_index = k[5:0];
         s.pivot_floored = floor_mem[k];
         s.last_result = (k == idx);
         solution_queue.push_back(s);
      end
      row_cnt = 0;
      pivot_reg = '0;
      upper_reg = '0;
   endtask

   task automatic report(input string what, input tts_pkg::rsp_type got,
                         input tts_pkg::rsp_type want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic [31:0] rand_word(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'h80000000;
         2: return 32'h7fffffff;
         3: return 32'h0;
         4: return 32'(int'($urandom_range(0, 262143)) - 131072);
         default: return 32'(int'($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   task automatic add_row(input logic [31:0] lo, input logic [31:0] dg, input logic [31:0] up,
                          input logic [31:0] rh, input logic lst);
      tts_pkg::req_type r;
      r.lower_coef = lo;
      r.diag_coef = dg;
      r.upper_coef = up;
      r.rhs_value = rh;
      r.last_row = lst;
      row_queue.push_back(r);
      gap_queue.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_row(req_data);
            void'(row_queue.pop_front());
            push_wait = gap_queue.pop_front();
         end
         if ((push && !full) || !push) begin
            if (row_queue.size() > 0 && push_wait == 0 &&
                !(drain_hold && solution_queue.size() > 0)) begin
               push <= 1'b1;
               req_data <= row_queue[0];
            end else begin
               push <= 1'b0;
               if (push_wait > 0) push_wait--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (solution_queue.size() == 0) begin
               report("unexpected", rsp_data, '0);
            end else begin
               if (rsp_data.solution_value !== solution_queue[0].solution_value)
                  report("solution_value", rsp_data, solution_queue[0]);
               if (rsp_data.row_index !== solution_queue[0].row_index)
                  report("row_index", rsp_data, solution_queue[0]);
               if (rsp_data.pivot_floored !== solution_queue[0].pivot_floored)
                  report("pivot_floored", rsp_data, solution_queue[0]);
               if (rsp_data.last_result !== solution_queue[0].last_result)
                  report("last_result", rsp_data, solution_queue[0]);
               void'(solution_queue.pop_front());
            end
            pop_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         end
         if (pop_wait == 0) begin
            pop <= 1'b1;
         end else begin
            pop <= 1'b0;
            pop_wait--;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int n;
      int mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // single row, extremes and floored pivots
      add_row(32'h0, 32'h00010000, 32'h0, 32'h00030000, 1'b1);
      add_row(32'h7fffffff, 32'h0, 32'h80000000, 32'h7fffffff, 1'b1);
      add_row(32'h80000000, 32'h00000001, 32'h7fffffff, 32'h80000000, 1'b0);
      add_row(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h7fffffff, 1'b0);
      add_row(32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 1'b1);
      // zero pivot on a later row
      add_row(32'h0, 32'h00010000, 32'h00010000, 32'h00010000, 1'b0);
      add_row(32'h00010000, 32'h00010000, 32'h0, 32'h00020000, 1'b1);
      // too many rows, no last mark
      for (int i = 0; i < ROWS; i++)
         add_row(32'hffff0000, 32'h00040000, 32'hffff0000, rand_word(4), 1'b0);
      add_row(32'h00010000, 32'h00020000, 32'h0, 32'h00010000, 1'b1);
      n = row_queue.size();
      while (n < 320) begin
         int len;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ROWS) : $urandom_range(1, 8);
         mode = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            add_row(rand_word($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : mode),
                    rand_word($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 5),
                    rand_word($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : mode),
                    rand_word($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : 0),
                    i == len - 1);
         end
         n += len;
         if (n > 150 && n - len <= 150) begin
            wait (row_queue.size() == 0);
            drain_hold = 1'b1;
            for (int i = 0; i < 3; i++) add_row(rand_word(5), rand_word(5), rand_word(5),
                                                rand_word(0), i == 2);
            n += 3;
            wait (row_queue.size() == 0 && solution_queue.size() == 0);
            drain_hold = 1'b0;
         end
      end
      wait (row_queue.size() == 0);
      wait (solution_queue.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
